// ----- rtl/ipcp_pkg.sv -----
package ipcp_pkg;

  // Characters the parser reacts to.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [2:0]  OCTET_MAX   = 3'd4;
  localparam logic [11:0] DEC_BASE    = 12'd10;
  localparam logic [11:0] FIELD_SAT   = 12'd256;
  localparam logic [11:0] OCTET_LIMIT = 12'd255;
  localparam logic [8:0]  PREFIX_MAX  = 9'd32;

  // Configuration space: one register, byte address 0.
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam logic        REG_REQ_NET = 1'b0;

  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    PH_ADDR   = 3'b001,
    PH_PREFIX = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_HOSTBITS = 2'd2,
    ST_HEX      = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [2:0]  cnt;
    logic [8:0]  fv;
    logic        seen;
    phase_t      phase;
    logic [1:0]  pos;
    status_t     err;
  } parse_state_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  plen;
    logic [31:0] addr;
  } parse_result_t;

endpackage

// ----- rtl/ipcp_parse.sv -----
module ipcp_parse
  import ipcp_pkg::*;
(
  input  parse_state_t  st_i,
  input  logic [7:0]    char_i,
  input  logic          req_net_i,
  output parse_state_t  st_o,
  output parse_result_t res_o
);

  // Place the current field into the address and start the next one.
  function automatic parse_state_t commit(parse_state_t s);
    parse_state_t r;
    r = s;
    if (s.cnt >= OCTET_MAX) begin
      r.err = ST_INVALID;
    end else begin
      r.addr = s.addr | ({24'd0, s.fv[7:0]} << {~s.cnt[1:0], 3'b000});
      r.cnt  = s.cnt + 3'd1;
      r.fv   = '0;
      r.seen = 1'b0;
    end
    return r;
  endfunction

  function automatic parse_state_t end_address(parse_state_t s);
    parse_state_t r;
    r = s;
    if (s.seen) begin
      r = commit(s);
    end else if (s.cnt == 3'd0) begin
      r.err = ST_INVALID;
    end
    return r;
  endfunction

  function automatic parse_state_t finish(parse_state_t s);
    parse_state_t r;
    r = s;
    if (s.err == ST_OK) begin
      if (s.phase == PH_ADDR) begin
        r    = end_address(s);
        r.fv = {3'b000, r.cnt, 3'b000};
      end else if (s.phase == PH_PREFIX) begin
        if (!s.seen || s.fv > PREFIX_MAX) r.err = ST_INVALID;
      end
    end
    r.phase = PH_DONE;
    return r;
  endfunction

  function automatic parse_state_t take_digit(parse_state_t s, logic [3:0] d);
    parse_state_t r;
    logic [11:0]  v;
    r = s;
    v = 12'(s.fv) * DEC_BASE + 12'(d);
    if (v > FIELD_SAT) v = FIELD_SAT;
    r.fv   = v[8:0];
    r.seen = 1'b1;
    if (s.phase == PH_ADDR && v > OCTET_LIMIT) r.err = ST_INVALID;
    return r;
  endfunction

  function automatic parse_state_t char_step(parse_state_t s, logic [7:0] c);
    parse_state_t r;
    logic         is_digit;
    logic [7:0]   dv;
    r        = s;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    dv       = c - CH_ZERO;
    if (c == CH_NUL) begin
      r = finish(s);
    end else begin
      if (s.phase == PH_ADDR) begin
        if (s.pos == 2'd1 && c == CH_X && s.seen && s.fv == 9'd0 && s.cnt == 3'd0) begin
          r.err = ST_HEX;
        end else if (is_digit) begin
          r = take_digit(s, dv[3:0]);
        end else if (c == CH_DOT) begin
          if (!s.seen || s.cnt >= OCTET_MAX - 3'd1) r.err = ST_INVALID;
          else r = commit(s);
        end else if (c == CH_SLASH) begin
          r       = end_address(s);
          r.phase = PH_PREFIX;
          r.fv    = '0;
          r.seen  = 1'b0;
        end else begin
          r.err = ST_INVALID;
        end
      end else begin
        if (is_digit) r = take_digit(s, dv[3:0]);
        else r.err = ST_INVALID;
      end
      if (s.pos < 2'd2) r.pos = s.pos + 2'd1;
    end
    return r;
  endfunction

  logic          live;
  logic          open_after;
  parse_state_t  s_char;
  parse_state_t  s_fin;
  logic [31:0]   host_mask;
  logic [5:0]    plen;

  assign live       = (st_i.phase == PH_ADDR || st_i.phase == PH_PREFIX) && st_i.err == ST_OK;
  assign open_after = (s_char.phase == PH_ADDR || s_char.phase == PH_PREFIX);

  always_comb begin
    s_char = st_i;
    if (live) begin
      s_char = char_step(st_i, char_i);
    end else if (char_i == CH_NUL) begin
      s_char.phase = PH_DONE;
    end
  end

  assign s_fin     = open_after ? finish(s_char) : s_char;
  assign st_o      = s_char;
  assign plen      = s_fin.fv[5:0];
  assign host_mask = 32'hFFFF_FFFF >> plen;

  always_comb begin
    res_o.status = s_fin.err;
    res_o.plen   = plen;
    res_o.addr   = s_fin.addr;
    if (s_fin.err == ST_OK && req_net_i && (s_fin.addr & host_mask) != 32'd0) begin
      res_o.status = ST_HOSTBITS;
    end
    if (res_o.status != ST_OK) begin
      res_o.plen = '0;
      res_o.addr = '0;
    end
  end

endmodule

// ----- rtl/ipv4_cidr_text_parser.sv -----
// IPv4 dotted-decimal text parser with an optional CIDR prefix length. Each input
// transaction carries one character in in_tdata, and in_tlast marks the last character
// of a text; a NUL character ends the text early and what follows it up to in_tlast is
// ignored. For every text exactly one result transaction comes out, after the in_tlast
// transaction, holding the address (first octet in bits 31..24), the prefix length
// (given, or eight times the number of octets) and a status: 0 ok, 1 invalid, 2 host
// bits set below the prefix while require_network is 1, 3 a hexadecimal "0x" form.
// Address and prefix length are zero whenever the status is not ok. The block takes one
// character per clock cycle with no gaps unless a last character is held back by a
// pending result: each character lands in an input register, and a single registered
// parse step updates the state and, on the last character, loads the result register,
// which drives out_tvalid. A result waiting on out_tready only stalls input once the last
// character of the next text needs the result register. require_network is written
// through the APB port at address 0 and should only be changed while no text is open.
module ipv4_cidr_text_parser
  import ipcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] text_char
  input  logic                  in_tlast,   // end_of_text

  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] address, [37:32] prefix_length,
                                            // [39:38] status

  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  // Configuration register. pready is tied high, so each access completes at once.
  logic req_net_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_REQ_NET);
  assign cfg_prdata = (cfg_paddr[2] == REG_REQ_NET) ? {31'd0, req_net_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_net_r <= 1'b0;
    end else if (cfg_wr) begin
      req_net_r <= cfg_pwdata[0];
    end
  end

  // Input register holding one character.
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_eot_r;

  // Output register.
  logic          out_valid_r;
  parse_result_t out_res_r;

  parse_state_t  st_r;
  parse_state_t  st_nxt;
  parse_state_t  st_char;
  parse_result_t res;

  logic out_free;
  logic s1_go;

  // The parse step retires the held character unless it is a last character whose
  // result cannot be written because the previous result is still pending.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!s1_eot_r || out_free);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_char_r <= in_tdata;
      s1_eot_r  <= in_tlast;
    end
  end

  ipcp_parse u_parse (
    .st_i      (st_r),
    .char_i    (s1_char_r),
    .req_net_i (req_net_r),
    .st_o      (st_char),
    .res_o     (res)
  );

  // The last character of a text returns the parse state to its starting point.
  always_comb begin
    st_nxt = st_char;
    if (s1_eot_r) begin
      st_nxt = '{addr: '0, cnt: '0, fv: '0, seen: 1'b0, phase: PH_ADDR, pos: '0, err: ST_OK};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{addr: '0, cnt: '0, fv: '0, seen: 1'b0, phase: PH_ADDR, pos: '0, err: ST_OK};
    end else if (s1_go) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_eot_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_eot_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.status, out_res_r.plen, out_res_r.addr};

  // An error result never carries an address or a prefix length.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status != ST_OK |-> out_res_r.addr == 32'd0
      && out_res_r.plen == 6'd0)
    else $error("error result with nonzero address or prefix length");

  // A good result has a prefix length of at most 32.
  a_plen_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status == ST_OK |-> out_res_r.plen <= 6'd32)
    else $error("prefix length above 32 on a good result");

  // Host bits are only reported while the network check is enabled.
  a_host_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status == ST_HOSTBITS |-> req_net_r)
    else $error("host bits status without require_network");

  // Retiring the last character of a text clears the parse state and posts a result.
  a_text_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_eot_r |=> st_r.phase == PH_ADDR && st_r.err == ST_OK
      && st_r.cnt == 3'd0 && out_valid_r)
    else $error("parse state not cleared after end of text");

  // No more than four octets are ever collected.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.cnt <= OCTET_MAX)
    else $error("octet count above four");

endmodule
